// ----- rtl/core/dstat_pkg.sv -----
// Package for the distribution statistics block: sizes, result kinds, types.
// No dependencies.
package dstat_pkg;

    localparam int MAX_STATES = 4096;
    localparam int TAIL_LIMIT = 10;
    localparam int AW = $clog2(MAX_STATES);
    localparam int CW = AW + 1;
    localparam int PW = 33;
    localparam int VW = 64;
    localparam int TW = 13;
    localparam int KW = 3;
    localparam int TLW = $clog2(TAIL_LIMIT + 1);

    localparam logic [KW-1:0] KIND_CDF  = 3'd0;
    localparam logic [KW-1:0] KIND_MEAN = 3'd1;
    localparam logic [KW-1:0] KIND_VAR  = 3'd2;
    localparam logic [KW-1:0] KIND_TAIL = 3'd3;
    localparam logic [KW-1:0] KIND_MODE = 3'd4;

    localparam logic [TW-1:0] TIE_MAX = 13'd8191;

    typedef struct packed {
        logic [KW-1:0] kind;
        logic [11:0]   index;
        logic [VW-1:0] value;
        logic [TW-1:0] tie_count;
        logic          last_result;
    } result_t;

    function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a,
                                              input logic [VW-1:0] b);
        logic [VW:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[VW] ? {VW{1'b1}} : s[VW-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/dstat_ram.sv -----
// Single-port-write, single-port-read synchronous store of probabilities.
// Depends on dstat_pkg.
module dstat_ram
    import dstat_pkg::*;
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [PW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [PW-1:0] rdata
);

    logic [PW-1:0] mem [MAX_STATES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/dstat_varterm.sv -----
// Pipelined variance term: floor(p*d*d/2^64), saturating, in several stages.
// Multiplies are cut into 32x32 partial products. Depends on dstat_pkg.
module dstat_varterm
    import dstat_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [PW-1:0] p,
    input  logic [VW-1:0] d,
    output logic          out_valid,
    output logic [VW-1:0] term
);

    // stage 1: d*d partial products
    logic [63:0] s1_p00_reg, s1_p01_reg, s1_p11_reg;
    logic [PW-1:0] s1_p_reg;
    // stage 2: d*d assembled (128 bits)
    logic [127:0] s2_dd_reg;
    logic [PW-1:0] s2_p_reg;
    // stage 3: p * d*d partial products (p split 32 + 1 bit)
    logic [63:0] s3_m0_reg, s3_m1_reg, s3_m2_reg, s3_m3_reg;
    logic        s3_ptop_reg;
    logic [127:0] s3_dd_reg;
    logic [2:0]  v_reg;

    logic [159:0] s3_sum;
    logic [160:0] s3_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            v_reg     <= {v_reg[1:0], in_valid};
            out_valid <= v_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_p00_reg <= d[31:0] * d[31:0];
        s1_p01_reg <= d[31:0] * d[63:32];
        s1_p11_reg <= d[63:32] * d[63:32];
        s1_p_reg   <= p;

        s2_dd_reg <= {64'd0, s1_p00_reg} + {31'd0, s1_p01_reg, 33'd0}
                     + {s1_p11_reg, 64'd0};
        s2_p_reg  <= s1_p_reg;

        s3_m0_reg   <= s2_p_reg[31:0] * s2_dd_reg[31:0];
        s3_m1_reg   <= s2_p_reg[31:0] * s2_dd_reg[63:32];
        s3_m2_reg   <= s2_p_reg[31:0] * s2_dd_reg[95:64];
        s3_m3_reg   <= s2_p_reg[31:0] * s2_dd_reg[127:96];
        s3_ptop_reg <= s2_p_reg[32];
        s3_dd_reg   <= s2_dd_reg;

        term <= (s3_full[160:128] != '0) ? {VW{1'b1}} : s3_full[127:64];
    end

    always_comb
    begin
        s3_sum  = {96'd0, s3_m0_reg} + {64'd0, s3_m1_reg, 32'd0}
                  + {32'd0, s3_m2_reg, 64'd0} + {s3_m3_reg, 96'd0};
        s3_full = {1'b0, s3_sum}
                  + (s3_ptop_reg ? {1'b0, s3_dd_reg, 32'd0} : 161'd0);
    end

endmodule

// ----- rtl/core/distribution_statistics.sv -----
// Top level of the distribution statistics block: entry load, summary walk.
// Depends on dstat_pkg, dstat_ram, dstat_varterm.
//
//  channel | dir | handshake        | payload
//  s_axis  | in  | tvalid / tready  | tdata probability, tlast final_entry
//  m_axis  | out | tvalid / tready  | tdata value, tuser kind/index/ties, tlast
//
// Entries load one per cycle while the output register is free; each stored
// entry emits its cdf result. The final entry starts a summary walk over the
// store through the one-read-port memory: the mean, then the variance pass
// (n reads into the four-stage term unit) and its emit, then each tail sum i
// (i reads, a drain, an emit), then the mode. No entry is taken during the
// summary. Reset clears all control state; the store is never cleared
// (entries are written before read). A stalled output holds its register
// and blocks further work.
module distribution_statistics
    import dstat_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [39:0]   s_axis_tdata,   // [32:0] probability, zero fill
    input  logic          s_axis_tlast,   // final_entry
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata,   // value
    output logic [27:0]   m_axis_tuser,   // [2:0] kind, [14:3] index, [27:15] tie_count
    output logic          m_axis_tlast    // last_result
);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_MEAN = 3'd1;
    localparam logic [2:0] ST_VAR  = 3'd2;
    localparam logic [2:0] ST_VOUT = 3'd3;
    localparam logic [2:0] ST_TAIL = 3'd4;
    localparam logic [2:0] ST_TOUT = 3'd5;
    localparam logic [2:0] ST_MODE = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [VW-1:0] cdf_reg, mean_reg, max_reg, acc_reg;
    logic [AW-1:0] mode_reg;
    logic [TW-1:0] ties_reg;
    logic [CW-1:0] issue_reg;     // reads issued in a walk
    logic [CW-1:0] got_reg;       // terms received
    logic          rd_pend_reg;
    logic [TLW-1:0] tail_i_reg;
    logic [TLW-1:0] tails_reg;

    result_t       out_reg;
    logic          out_valid_reg;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [PW-1:0] ram_rdata;
    logic          vt_in_valid, vt_out_valid;
    logic [VW-1:0] vt_d, vt_term, pos;
    logic [CW-1:0] rd_idx;

    logic          out_free;
    logic          in_fire;
    logic [PW-1:0] in_p;
    logic          store_ok;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_LOAD) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_p          = s_axis_tdata[PW-1:0];
    assign store_ok      = count_reg < CW'(MAX_STATES);
    assign ram_we        = in_fire && store_ok;

    // variance walk reads 0..n-1, tail walk reads n-i..n-1
    always_comb
    begin
        rd_idx = issue_reg;
        if (state_reg == ST_TAIL)
        begin
            rd_idx = count_reg - CW'(tail_i_reg) + issue_reg;
        end
    end
    assign ram_raddr = rd_idx[AW-1:0];

    dstat_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_p),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [CW-1:0] d_idx_reg;
    assign pos         = {{(32-CW){1'b0}}, d_idx_reg, 32'd0};
    assign vt_d        = (pos >= mean_reg) ? pos - mean_reg : mean_reg - pos;
    assign vt_in_valid = rd_pend_reg && (state_reg == ST_VAR);

    dstat_varterm u_vt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vt_in_valid),
        .p         (ram_rdata),
        .d         (vt_d),
        .out_valid (vt_out_valid),
        .term      (vt_term)
    );

    logic walk_issue;
    always_comb
    begin
        walk_issue = 1'b0;
        if (state_reg == ST_VAR)
        begin
            walk_issue = issue_reg < count_reg;
        end
        else if (state_reg == ST_TAIL)
        begin
            walk_issue = issue_reg < CW'(tail_i_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: if (in_fire && s_axis_tlast) state_next = ST_MEAN;
            ST_MEAN: if (out_free) state_next = ST_VAR;
            ST_VAR:  if (got_reg == count_reg && !rd_pend_reg && !walk_issue)
                         state_next = ST_VOUT;
            ST_VOUT: if (out_free)
                         state_next = (tails_reg > TLW'(1)) ? ST_TAIL : ST_MODE;
            ST_TAIL: if (!walk_issue && !rd_pend_reg) state_next = ST_TOUT;
            ST_TOUT: if (out_free)
                         state_next = (tail_i_reg + TLW'(1) < tails_reg) ? ST_TAIL : ST_MODE;
            ST_MODE: if (out_free) state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            cdf_reg       <= '0;
            mean_reg      <= '0;
            max_reg       <= '0;
            mode_reg      <= '0;
            ties_reg      <= TW'(1);
            acc_reg       <= '0;
            issue_reg     <= '0;
            got_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            d_idx_reg     <= '0;
            tail_i_reg    <= '0;
            tails_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_pend_reg <= walk_issue;
            d_idx_reg   <= issue_reg;
            if (walk_issue)
            begin
                issue_reg <= issue_reg + CW'(1);
            end
            if (rd_pend_reg && state_reg == ST_TAIL)
            begin
                acc_reg <= sat_add(acc_reg, {31'd0, ram_rdata});
            end
            if (vt_out_valid)
            begin
                acc_reg <= sat_add(acc_reg, vt_term);
                got_reg <= got_reg + CW'(1);
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (store_ok)
                        begin
                            cdf_reg  <= sat_add(cdf_reg, {31'd0, in_p});
                            mean_reg <= sat_add(mean_reg,
                                                VW'(count_reg * in_p));
                            if ({31'd0, in_p} > max_reg)
                            begin
                                max_reg  <= {31'd0, in_p};
                                mode_reg <= count_reg[AW-1:0];
                                ties_reg <= TW'(1);
                            end
                            else if ({31'd0, in_p} == max_reg && ties_reg < TIE_MAX)
                            begin
                                ties_reg <= ties_reg + TW'(1);
                            end
                            count_reg <= count_reg + CW'(1);
                            out_valid_reg <= 1'b1;
                            out_reg <= '{KIND_CDF, 12'(count_reg),
                                         sat_add(cdf_reg, {31'd0, in_p}), '0, 1'b0};
                        end
                        if (s_axis_tlast)
                        begin
                            issue_reg <= '0;
                            got_reg   <= '0;
                            acc_reg   <= '0;
                        end
                    end
                end
                ST_MEAN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg <= '{KIND_MEAN, 12'd0, mean_reg, '0, 1'b0};
                        tails_reg <= (count_reg < CW'(TAIL_LIMIT)) ?
                                     TLW'(count_reg) : TLW'(TAIL_LIMIT);
                        tail_i_reg <= TLW'(1);
                    end
                end
                ST_VAR: ;
                ST_VOUT, ST_TOUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg <= '{(state_reg == ST_VOUT) ? KIND_VAR : KIND_TAIL,
                                     (state_reg == ST_VOUT) ? 12'd0 : 12'(tail_i_reg),
                                     acc_reg, '0, 1'b0};
                        acc_reg   <= '0;
                        issue_reg <= '0;
                        if (state_reg == ST_TOUT)
                        begin
                            tail_i_reg <= tail_i_reg + TLW'(1);
                        end
                    end
                end
                ST_TAIL: ;
                ST_MODE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg <= '{KIND_MODE, 12'(mode_reg), max_reg, ties_reg, 1'b1};
                        count_reg <= '0;
                        cdf_reg   <= '0;
                        mean_reg  <= '0;
                        max_reg   <= '0;
                        mode_reg  <= '0;
                        ties_reg  <= TW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.value;
    assign m_axis_tuser  = {out_reg.tie_count, out_reg.index, out_reg.kind};
    assign m_axis_tlast  = out_reg.last_result;

    a_ready_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == ST_LOAD)
        else $error("input ready outside load");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_STATES))
        else $error("entry count overflow");
    a_ties_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ties_reg != '0)
        else $error("tie count zero");
    a_mode_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODE && out_free) |=> count_reg == '0)
        else $error("run state not cleared");

endmodule

// ----- verif/dstat_checker.sv -----
`timescale 1ns / 1ps
// Checker for the distribution statistics block: watches both stream channels,
// predicts cdf, mean, variance, tail and mode results, compares. Needs dstat_pkg.
module dstat_checker
    import dstat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [27:0] m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    logic [PW-1:0] prob_mem [MAX_STATES];
    int            n_held;
    logic [VW-1:0] cdf_acc;
    logic [VW-1:0] mean_acc;
    logic [11:0]   peak_idx;
    logic [PW-1:0] peak_prob;
    logic [TW-1:0] peak_ties;
    result_t       expected_q [$];

    assign pending = expected_q.size();

    function automatic logic [VW-1:0] add_sat(input logic [VW-1:0] a,
                                              input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VW] ? {VW{1'b1}} : s[VW-1:0];
    endfunction

    // floor(p*d*d / 2^64), saturating
    function automatic logic [VW-1:0] spread_term(input logic [PW-1:0] p,
                                                  input logic [VW-1:0] d);
        logic [127:0] dsq;
        logic [160:0] prod;
        dsq  = {64'd0, d} * {64'd0, d};
        prod = {33'd0, dsq} * {128'd0, p};
        prod = prod >> 64;
        return (prod[160:64] != 0) ? {VW{1'b1}} : prod[63:0];
    endfunction

    task automatic push(input logic [KW-1:0] k, input logic [11:0] idx,
                        input logic [VW-1:0] v, input logic [TW-1:0] t,
                        input logic lst);
        result_t r;
        r.kind = k; r.index = idx; r.value = v; r.tie_count = t; r.last_result = lst;
        expected_q.push_back(r);
    endtask

    task automatic report(input string what, input logic [VW-1:0] got,
                          input logic [VW-1:0] want);
        fail_count++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    task automatic take_entry(input logic [PW-1:0] p, input logic fin);
        logic [VW-1:0] spread, tsum, pos, d;
        int tails;
        if (n_held < MAX_STATES) begin
            prob_mem[n_held] = p;
            cdf_acc  = add_sat(cdf_acc, p);
            mean_acc = add_sat(mean_acc, 64'(n_held) * 64'(p));
            if (p > peak_prob) begin
                peak_prob = p; peak_idx = 12'(n_held); peak_ties = 1;
            end else if (p == peak_prob && peak_ties < TIE_MAX) begin
                peak_ties++;
            end
            push(KIND_CDF, 12'(n_held), cdf_acc, 0, 1'b0);
            n_held++;
        end
        if (fin) begin
            push(KIND_MEAN, 0, mean_acc, 0, 1'b0);
            spread = 0;
            for (int j = 0; j < n_held; j++) begin
                pos = 64'(j) << 32;
                d = (pos >= mean_acc) ? pos - mean_acc : mean_acc - pos;
                spread = add_sat(spread, spread_term(prob_mem[j], d));
            end
            push(KIND_VAR, 0, spread, 0, 1'b0);
            tails = (n_held < TAIL_LIMIT) ? n_held : TAIL_LIMIT;
            for (int i = 1; i < tails; i++) begin
                tsum = 0;
                for (int j = n_held - i; j < n_held; j++)
                    tsum = add_sat(tsum, prob_mem[j]);
                push(KIND_TAIL, 12'(i), tsum, 0, 1'b0);
            end
            push(KIND_MODE, peak_idx, 64'(peak_prob), peak_ties, 1'b1);
            n_held = 0; cdf_acc = 0; mean_acc = 0;
            peak_idx = 0; peak_prob = 0; peak_ties = 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            fail_count = 0; results_seen = 0;
            n_held = 0; cdf_acc = 0; mean_acc = 0;
            peak_idx = 0; peak_prob = 0; peak_ties = 1;
            expected_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                take_entry(s_axis_tdata[32:0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                    report("unexpected result, kind", m_axis_tuser[2:0], 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (m_axis_tuser[2:0] != want.kind)
                        report("kind", m_axis_tuser[2:0], want.kind);
                    if (m_axis_tuser[14:3] != want.index)
                        report("index", m_axis_tuser[14:3], want.index);
                    if (m_axis_tdata != want.value)
                        report("value", m_axis_tdata, want.value);
                    if (m_axis_tuser[27:15] != want.tie_count)
                        report("tie_count", m_axis_tuser[27:15], want.tie_count);
                    if (m_axis_tlast != want.last_result)
                        report("last_result", m_axis_tlast, want.last_result);
                end
            end
        end
    end

endmodule

// ----- verif/tb_distribution_statistics.sv -----
`timescale 1ns / 1ps
// Testbench top for distribution_statistics: clock, reset, vector stimulus,
// output back-pressure and verdict. Needs dstat_pkg and dstat_checker.
module tb_distribution_statistics;
    import dstat_pkg::*;

    localparam logic [32:0] P_ONE = 33'h1_0000_0000;
    localparam int CYCLE_LIMIT = 900000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [27:0] m_axis_tuser;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          cycles = 0;
    int          entries_sent;
    int          vectors_sent;
    bit          hold_long;
    bit          long_hold_done;

    distribution_statistics u_top (.*);

    dstat_checker u_chk (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold while the sender keeps going
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long && !long_hold_done)
            begin
                m_axis_tready = 1'b0;
                repeat (400) @(negedge clk);
                long_hold_done = 1'b1;
            end
            else if ($urandom_range(0, 9) < 2)
            begin
                m_axis_tready = 1'b0;
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
                repeat (n - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    task automatic send(input logic [32:0] p, input logic fin, input bit gaps);
        int n;
        if (gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid = 1'b0;
            n = ($urandom_range(0, 12) == 0) ? $urandom_range(8, 30)
                                              : $urandom_range(1, 3);
            repeat (n) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, p};
        s_axis_tlast  = fin;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        entries_sent++;
        if (fin) vectors_sent++;
    endtask

    function automatic logic [32:0] rand_prob();
        case ($urandom_range(0, 7))
            0: return 33'd0;
            1: return P_ONE;
            2: return {1'($urandom_range(0, 1)), $urandom};
            3: return 33'($urandom_range(0, 3)) << 30;
            default: return 33'($urandom_range(0, 32'h4000_0000));
        endcase
    endfunction

    task automatic send_vector(input int len, input bit gaps);
        for (int j = 0; j < len; j++)
            send(rand_prob(), j == len - 1, gaps);
    endtask

    initial
    begin
        int len;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        entries_sent = 0; vectors_sent = 0;
        hold_long = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single entry: no tail sums
        send(P_ONE, 1'b1, 0);
        // all zeros: mode index 0, ties grow with every entry
        send(33'd0, 1'b0, 0); send(33'd0, 1'b0, 0); send(33'd0, 1'b1, 0);
        // zeros before the first positive entry, then ties with the max
        send(33'd0, 1'b0, 0); send(33'h0_8000_0000, 1'b0, 0);
        send(33'h0_8000_0000, 1'b1, 0);
        // maxima everywhere: every entry the largest 33-bit value, full tail set
        for (int j = 0; j < 12; j++)
            send(33'h1_FFFF_FFFF, j == 11, 0);
        // exactly TAIL_LIMIT entries, alternating bits
        for (int j = 0; j < TAIL_LIMIT; j++)
            send((j % 2) ? 33'h0_AAAA_AAAA : 33'h1_5555_5555, j == TAIL_LIMIT - 1, 0);

        // long receiver hold while entries keep coming
        hold_long = 1'b1;
        send_vector(30, 0);

        while (entries_sent < 310)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 14);
            send_vector(len, 1);
        end

        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        $display("Sent %0d entries in %0d vectors; checked %0d results.",
                 entries_sent, vectors_sent, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
